/* hw/rtl/tqdoq_pkg.sv */
// ============================================================================
// tqdoq_pkg: shared constants for the topic quota queue
// Register indexes, operation and drop codes, field widths and defaults.
// ============================================================================
package tqdoq_pkg;

    // Default sizing handed to the top level.
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_NUM_TOPICS   = 8;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Configuration port.
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOPIC_QUOTA = 1'b1;

    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RESET = 5'd16;
    localparam logic [CFG_W-1:0] TOPIC_QUOTA_RESET = 5'd16;

    // Operation codes.
    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_POP     = 1'b1;

    // Drop kinds reported with each result.
    localparam int DROP_KIND_W = 2;
    localparam logic [DROP_KIND_W-1:0] DROP_NONE   = 2'd0;
    localparam logic [DROP_KIND_W-1:0] DROP_QUOTA  = 2'd1;
    localparam logic [DROP_KIND_W-1:0] DROP_OLDEST = 2'd2;

    // Saturating drop counter.
    localparam int DROP_W = 32;
    localparam logic [DROP_W-1:0] DROP_MAX = 32'hFFFF_FFFF;

endpackage

/* hw/rtl/topic_quota_drop_oldest_queue_unit.sv */
// ============================================================================
// topic_quota_drop_oldest_queue_unit: bounded event queue with topic quotas
// Event queue in a circular buffer memory, walked by a small sequencer.
// ============================================================================
// A start with busy low hands in one word: a publish (op 0) or a pop (op 1).
// The block then stays busy while its sequencer walks the queue memory one
// entry at a time through a single shared address adder and one read port.
// A pop reads the head entry and returns it, or ends with no event when
// the queue is empty. A publish reads every queued entry and compares its
// topic to count the topic's occupancy and find its oldest entry; when
// the topic's quota forces an eviction, every entry behind the evicted one
// moves up a place to close the gap, one read and one write per entry
// moved. The result word appears for exactly one cycle with done high, and
// the receiver cannot stall it; busy is already low in that cycle, so the
// next start may be taken at once. drop_count and fill show the running
// totals and are valid whenever done is high. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be issued while the
// block is not busy. There is no clearing pass after reset: the fill level
// and head pointer reset, and entries beyond the fill are never used.
module topic_quota_drop_oldest_queue_unit #(
    parameter int  QUEUE_DEPTH  = tqdoq_pkg::DEF_QUEUE_DEPTH,
    parameter int  NUM_TOPICS   = tqdoq_pkg::DEF_NUM_TOPICS,
    parameter int  PAYLOAD_BITS = tqdoq_pkg::DEF_PAYLOAD_BITS,
    localparam int TW           = $clog2(NUM_TOPICS),
    localparam int FW           = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic [TW-1:0]                        topic,
    input  logic [PAYLOAD_BITS-1:0]              payload,
    // Result side
    output logic                                 done,
    output logic                                 event_valid,
    output logic [TW-1:0]                        event_topic,
    output logic [PAYLOAD_BITS-1:0]              event_payload,
    output logic [tqdoq_pkg::DROP_KIND_W-1:0]    drop_kind,
    output logic [tqdoq_pkg::DROP_W-1:0]         drop_count,
    output logic [FW-1:0]                        fill,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tqdoq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqdoq_pkg::CFG_W-1:0]          cfg_data
);
    import tqdoq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = TW + PAYLOAD_BITS;
    // Compare width wide enough for both the fill and a configuration value.
    localparam int CW = (FW > CFG_W) ? FW : CFG_W;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b0_0000_0001,
        ST_SCAN_RD   = 9'b0_0000_0010,
        ST_SCAN_CMP  = 9'b0_0000_0100,
        ST_SHIFT_RD  = 9'b0_0000_1000,
        ST_SHIFT_WR  = 9'b0_0001_0000,
        ST_LIMIT     = 9'b0_0010_0000,
        ST_APPEND    = 9'b0_0100_0000,
        ST_POP_RD    = 9'b0_1000_0000,
        ST_POP_OUT   = 9'b1_0000_0000
    } state_t;

    // Sequencer and queue bookkeeping.
    state_t                  state_reg,   state_next;
    logic [AW-1:0]           head_reg,    head_next;
    logic [FW-1:0]           fill_reg,    fill_next;
    logic [FW-1:0]           idx_reg,     idx_next;
    logic [FW-1:0]           cnt_reg,     cnt_next;
    logic [FW-1:0]           first_reg,   first_next;
    logic                    found_reg,   found_next;
    logic [DROP_KIND_W-1:0]  kind_reg,    kind_next;
    logic [DROP_W-1:0]       drop_reg,    drop_next;

    // Captured command word.
    logic [TW-1:0]           topic_reg,   topic_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    // Configuration registers.
    logic [CFG_W-1:0]        limit_reg,   limit_next;
    logic [CFG_W-1:0]        quota_reg,   quota_next;

    // Result word.
    logic                    done_reg,     done_next;
    logic                    ev_valid_reg, ev_valid_next;
    logic [TW-1:0]           ev_topic_reg, ev_topic_next;
    logic [PAYLOAD_BITS-1:0] ev_pay_reg,   ev_pay_next;
    logic [DROP_KIND_W-1:0]  out_kind_reg, out_kind_next;

    // Queue memory: slot position p lives at address (head + p) mod depth.
    logic [EW-1:0]           mem [QUEUE_DEPTH];
    logic [EW-1:0]           rd_data_reg;
    logic                    mem_we;
    logic [EW-1:0]           mem_wdata;
    logic [AW-1:0]           mem_addr;

    // Shared position-to-address adder.
    logic [FW-1:0]           pos;
    logic [FW:0]             addr_sum;
    logic [FW:0]             addr_wrap;

    logic [TW:0]             topic_ext;
    logic [TW-1:0]           topic_mod;
    logic [FW-1:0]           idx_inc;
    logic [AW:0]             head_inc;
    logic [AW-1:0]           head_adv;
    logic [CW-1:0]           limit_eff;
    logic [DROP_W-1:0]       drop_inc;
    logic [TW-1:0]           rd_topic;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    assign rd_topic   = rd_data_reg[EW-1:PAYLOAD_BITS];
    assign rd_payload = rd_data_reg[PAYLOAD_BITS-1:0];
    assign idx_inc    = idx_reg + FW'(1);

    // Topic indexes fold back into range; one subtraction suffices.
    assign topic_ext = {1'b0, topic};
    assign topic_mod = (topic_ext >= (TW+1)'(NUM_TOPICS))
                       ? TW'(topic_ext - (TW+1)'(NUM_TOPICS)) : topic;

    // A limit of zero behaves as one, and anything above the depth as the depth.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = CW'(1);
        end
        else if (CW'(limit_reg) > CW'(QUEUE_DEPTH))
        begin
            limit_eff = CW'(QUEUE_DEPTH);
        end
        else
        begin
            limit_eff = CW'(limit_reg);
        end
    end

    assign head_inc = (AW+1)'(head_reg) + (AW+1)'(1);
    assign head_adv = (head_inc == (AW+1)'(QUEUE_DEPTH)) ? '0 : AW'(head_inc);
    assign drop_inc = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + DROP_W'(1);

    // Queue position driven onto the shared adder in each state.
    always_comb
    begin
        case (state_reg)
            ST_SCAN_RD:  pos = idx_reg;
            ST_SHIFT_RD: pos = idx_inc;
            ST_SHIFT_WR: pos = idx_reg;
            ST_APPEND:   pos = fill_reg;
            default:     pos = '0;
        endcase
    end

    assign addr_sum  = (FW+1)'(head_reg) + (FW+1)'(pos);
    assign addr_wrap = (addr_sum >= (FW+1)'(QUEUE_DEPTH))
                       ? addr_sum - (FW+1)'(QUEUE_DEPTH) : addr_sum;
    assign mem_addr  = AW'(addr_wrap);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        first_next    = first_reg;
        found_next    = found_reg;
        kind_next     = kind_reg;
        drop_next     = drop_reg;
        topic_next    = topic_reg;
        payload_next  = payload_reg;
        limit_next    = limit_reg;
        quota_next    = quota_reg;
        done_next     = 1'b0;
        ev_valid_next = ev_valid_reg;
        ev_topic_next = ev_topic_reg;
        ev_pay_next   = ev_pay_reg;
        out_kind_next = out_kind_reg;
        mem_we        = 1'b0;
        mem_wdata     = rd_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_QUEUE_LIMIT: limit_next = cfg_data;
                REG_TOPIC_QUOTA: quota_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    topic_next   = topic_mod;
                    payload_next = payload;
                    idx_next     = '0;
                    cnt_next     = '0;
                    first_next   = '0;
                    found_next   = 1'b0;
                    kind_next    = DROP_NONE;
                    state_next   = (op == OP_PUBLISH) ? ST_SCAN_RD : ST_POP_RD;
                end
            end

            ST_SCAN_RD:
            begin
                if (idx_reg < fill_reg)
                begin
                    state_next = ST_SCAN_CMP;
                end
                else if (found_reg && (CW'(cnt_reg) >= CW'(quota_reg)))
                begin
                    idx_next   = first_reg;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_LIMIT;
                end
            end

            ST_SCAN_CMP:
            begin
                if (rd_topic == topic_reg)
                begin
                    cnt_next = cnt_reg + FW'(1);
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        first_next = idx_reg;
                    end
                end
                idx_next   = idx_inc;
                state_next = ST_SCAN_RD;
            end

            ST_SHIFT_RD:
            begin
                if (idx_inc < fill_reg)
                begin
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    fill_next  = fill_reg - FW'(1);
                    drop_next  = drop_inc;
                    kind_next  = DROP_QUOTA;
                    state_next = ST_LIMIT;
                end
            end

            ST_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                idx_next   = idx_inc;
                state_next = ST_SHIFT_RD;
            end

            ST_LIMIT:
            begin
                if ((CW'(fill_reg) >= limit_eff) && (fill_reg != '0))
                begin
                    head_next = head_adv;
                    fill_next = fill_reg - FW'(1);
                    drop_next = drop_inc;
                    kind_next = DROP_OLDEST;
                end
                state_next = ST_APPEND;
            end

            ST_APPEND:
            begin
                mem_we        = 1'b1;
                mem_wdata     = {topic_reg, payload_reg};
                fill_next     = fill_reg + FW'(1);
                done_next     = 1'b1;
                ev_valid_next = 1'b0;
                ev_topic_next = '0;
                ev_pay_next   = '0;
                out_kind_next = kind_reg;
                state_next    = ST_IDLE;
            end

            ST_POP_RD:
            begin
                if (fill_reg == '0)
                begin
                    done_next     = 1'b1;
                    ev_valid_next = 1'b0;
                    ev_topic_next = '0;
                    ev_pay_next   = '0;
                    out_kind_next = DROP_NONE;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_POP_OUT;
                end
            end

            ST_POP_OUT:
            begin
                head_next     = head_adv;
                fill_next     = fill_reg - FW'(1);
                done_next     = 1'b1;
                ev_valid_next = 1'b1;
                ev_topic_next = rd_topic;
                ev_pay_next   = rd_payload;
                out_kind_next = DROP_NONE;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state resets; the captured command word carries no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            first_reg    <= '0;
            found_reg    <= 1'b0;
            kind_reg     <= DROP_NONE;
            drop_reg     <= '0;
            limit_reg    <= QUEUE_LIMIT_RESET;
            quota_reg    <= TOPIC_QUOTA_RESET;
            done_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            ev_topic_reg <= '0;
            ev_pay_reg   <= '0;
            out_kind_reg <= DROP_NONE;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            found_reg    <= found_next;
            kind_reg     <= kind_next;
            drop_reg     <= drop_next;
            limit_reg    <= limit_next;
            quota_reg    <= quota_next;
            done_reg     <= done_next;
            ev_valid_reg <= ev_valid_next;
            ev_topic_reg <= ev_topic_next;
            ev_pay_reg   <= ev_pay_next;
            out_kind_reg <= out_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        topic_reg   <= topic_next;
        payload_reg <= payload_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign event_valid   = ev_valid_reg;
    assign event_topic   = ev_topic_reg;
    assign event_payload = ev_pay_reg;
    assign drop_kind     = out_kind_reg;
    assign drop_count    = drop_reg;
    assign fill          = fill_reg;
    assign cfg_ready     = 1'b1;

endmodule

/* hw/rtl/tqdoq_checker.sv */
// ============================================================================
// tqdoq_checker: port-level checks for the topic quota queue
// Watches the command and result ports over time.
// ============================================================================
module tqdoq_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic                                 event_valid,
    input logic [tqdoq_pkg::DROP_KIND_W-1:0]    drop_kind,
    input logic [tqdoq_pkg::DROP_W-1:0]         drop_count
);
    import tqdoq_pkg::*;

    // An accepted word always keeps the block busy in the next cycle.
    a_accept_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("accepted word did not make the block busy");

    // The result cycle is also the first cycle in which a new word may enter.
    a_done_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy
    ) else $error("result shown while the block is still busy");

    // A returned event comes from a pop, which never evicts anything.
    a_pop_no_drop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && event_valid) |-> (drop_kind == DROP_NONE)
    ) else $error("pop result reports an eviction");

    // Without an eviction the drop total on the result must equal its $past value.
    a_drop_steady: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (drop_kind == DROP_NONE)) |-> (drop_count == $past(drop_count))
    ) else $error("drop total changed on an item without eviction");

    // Any eviction leaves a non-zero drop total behind.
    a_drop_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (drop_kind != DROP_NONE)) |-> (drop_count != '0)
    ) else $error("eviction reported but drop total is zero");

endmodule

bind topic_quota_drop_oldest_queue_unit tqdoq_checker u_tqdoq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .event_valid (event_valid),
    .drop_kind   (drop_kind),
    .drop_count  (drop_count)
);
